[src/hco_pkg.sv]
package hco_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned PixW   = 16;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    OP_PIXEL     = 2'd0,
    OP_SPRITE_WR = 2'd1,
    OP_PALETTE_WR = 2'd2
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CURSOR_X      = 3'd0,
    REG_CURSOR_Y      = 3'd1,
    REG_HOTSPOT_X     = 3'd2,
    REG_HOTSPOT_Y     = 3'd3,
    REG_CURSOR_ENABLE = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [PixW-1:0]   background_pixel;
    logic [IdxW-1:0]   table_index;
    logic [PixW-1:0]   table_data;
  } pix_t;

  typedef struct packed {
    logic            is_pix;
    logic            pal_we;
    logic [IdxW-1:0] pal_idx;
    logic [PixW-1:0] pal_data;
    logic            hit;
    logic [PixW-1:0] bg;
  } s1_t;

  typedef struct packed {
    logic            hit;
    logic [PixW-1:0] bg;
  } s2_t;

  function automatic logic [3:0] mix4(input logic [3:0] bg, input logic [3:0] fg,
                                      input logic [3:0] a);
    logic [9:0] sum;
    sum = 10'(bg * (5'd16 - {1'b0, a})) + 10'(fg * ({1'b0, a} + 5'd1));
    return sum[7:4];
  endfunction

endpackage

[src/hco_pix_if.sv]
interface hco_pix_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [15:0] background_pixel;
  logic [7:0]  table_index;
  logic [15:0] table_data;

  modport source (
    output valid, opcode, pixel_x, pixel_y, background_pixel, table_index, table_data,
    input  ready
  );
  modport sink (
    input  valid, opcode, pixel_x, pixel_y, background_pixel, table_index, table_data,
    output ready
  );
endinterface

[src/hco_res_if.sv]
interface hco_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;
  logic        cursor_drawn;

  modport source (
    output valid, pixel_out, cursor_drawn,
    input  ready
  );
  modport sink (
    input  valid, pixel_out, cursor_drawn,
    output ready
  );
endinterface

[src/hco_sprite.sv]
module hco_sprite import hco_pkg::*; #(
  parameter int unsigned CURSOR_SIZE = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               acc_i,
  input  pix_t               pix_i,
  input  logic               cursor_enable_i,
  input  logic [16:0]        corner_x_i,
  input  logic [16:0]        corner_y_i,
  output logic               s1_valid_o,
  output s1_t                s1_o,
  output logic [IdxW-1:0]    spr_data_o
);

  localparam int unsigned CW         = $clog2(CURSOR_SIZE);
  localparam int unsigned SprEntries = CURSOR_SIZE * CURSOR_SIZE;
  localparam int unsigned SAW        = $clog2(SprEntries);

  logic [IdxW-1:0] mem [SprEntries];
  logic [17:0]     h, v;
  logic            hit;
  logic [SAW-1:0]  raddr, waddr;
  logic            spr_we;
  logic            valid_d, valid_q;
  s1_t             s1_d, s1_q;
  logic [IdxW-1:0] rd_q;

  assign h = {6'b0, pix_i.pixel_x} - {corner_x_i[16], corner_x_i};
  assign v = {6'b0, pix_i.pixel_y} - {corner_y_i[16], corner_y_i};
  assign hit = cursor_enable_i && !h[17] && (h < 18'(CURSOR_SIZE))
               && !v[17] && (v < 18'(CURSOR_SIZE));

  assign raddr = SAW'(SAW'(v[CW-1:0]) * SAW'(CURSOR_SIZE)) + SAW'(h[CW-1:0]);
  assign waddr = SAW'(pix_i.table_index);
  assign spr_we = acc_i && (pix_i.opcode == OP_SPRITE_WR)
                  && (32'(pix_i.table_index) < 32'(SprEntries));

  always_comb begin
    s1_d.is_pix   = (pix_i.opcode == OP_PIXEL);
    s1_d.pal_we   = (pix_i.opcode == OP_PALETTE_WR);
    s1_d.pal_idx  = pix_i.table_index;
    s1_d.pal_data = pix_i.table_data;
    s1_d.hit      = hit;
    s1_d.bg       = pix_i.background_pixel;
    valid_d       = valid_q;
    if (en_i) begin
      valid_d = acc_i && (s1_d.is_pix || s1_d.pal_we);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      rd_q <= mem[raddr];
    end
    if (spr_we) begin
      mem[waddr] <= pix_i.table_data[IdxW-1:0];
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_o       = s1_q;
  assign spr_data_o = rd_q;

endmodule

[src/hco_palette.sv]
module hco_palette import hco_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            s1_valid_i,
  input  s1_t             s1_i,
  input  logic [IdxW-1:0] spr_data_i,
  output logic            s2_valid_o,
  output s2_t             s2_o,
  output logic [PixW-1:0] pal_data_o
);

  localparam int unsigned PAW = $clog2(PALETTE_ENTRIES);

  logic [PixW-1:0] mem [PALETTE_ENTRIES];
  logic            pal_we;
  logic            valid_d, valid_q;
  s2_t             s2_d, s2_q;
  logic [PixW-1:0] rd_q;

  assign pal_we = en_i && s1_valid_i && s1_i.pal_we
                  && (32'(s1_i.pal_idx) < 32'(PALETTE_ENTRIES));

  always_comb begin
    s2_d.hit = s1_i.hit && (32'(spr_data_i) < 32'(PALETTE_ENTRIES));
    s2_d.bg  = s1_i.bg;
    valid_d  = valid_q;
    if (en_i) begin
      valid_d = s1_valid_i && s1_i.is_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
      rd_q <= mem[PAW'(spr_data_i)];
    end
    if (pal_we) begin
      mem[PAW'(s1_i.pal_idx)] <= s1_i.pal_data;
    end
  end

  assign s2_valid_o = valid_q;
  assign s2_o       = s2_q;
  assign pal_data_o = rd_q;

endmodule

[src/hco_blend.sv]
module hco_blend import hco_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            s2_valid_i,
  input  s2_t             s2_i,
  input  logic [PixW-1:0] pal_data_i,
  output logic            valid_o,
  output logic [PixW-1:0] pixel_o,
  output logic            drawn_o
);

  logic [3:0]      alpha;
  logic            drawn_d, drawn_q;
  logic [PixW-1:0] pixel_d, pixel_q;
  logic            valid_d, valid_q;

  assign alpha = pal_data_i[15:12];

  always_comb begin
    drawn_d = s2_i.hit && (alpha != 4'd0);
    pixel_d = s2_i.bg;
    if (drawn_d) begin
      pixel_d = {alpha,
                 mix4(s2_i.bg[11:8], pal_data_i[11:8], alpha),
                 mix4(s2_i.bg[7:4],  pal_data_i[7:4],  alpha),
                 mix4(s2_i.bg[3:0],  pal_data_i[3:0],  alpha)};
    end
    valid_d = en_i ? s2_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pixel_q <= pixel_d;
      drawn_q <= drawn_d;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;
  assign drawn_o = drawn_q;

endmodule

[src/hardware_cursor_overlay.sv]
// A pixel transaction passes the sprite, palette and blend registers before its result appears.
// Throughput: one transaction per cycle unless the result side stalls; writes go at the same rate.
// The rate is set by the pipeline sprite read, palette read, blend, each stage one
// synchronous memory port or the output register, stalling only from the result side.
// Reset clears the pipeline valid flags and the registers (cursor enabled, positions zero).
// Sprite and palette contents are not cleared and must be written before use.
module hardware_cursor_overlay import hco_pkg::*; #(
  parameter int unsigned CURSOR_SIZE     = 16,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  hco_pix_if.sink            pix_i,
  hco_res_if.source          res_o
);

  logic [15:0] cursor_x_q, cursor_y_q;
  logic [7:0]  hotspot_x_q, hotspot_y_q;
  logic        cursor_enable_q;
  logic [16:0] corner_x, corner_y;

  pix_t            pix;
  logic            en1, en2, en3, acc;
  logic            s1_valid, s2_valid, s3_valid;
  s1_t             s1;
  s2_t             s2;
  logic [IdxW-1:0] spr_data;
  logic [PixW-1:0] pal_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q      <= '0;
      cursor_y_q      <= '0;
      hotspot_x_q     <= '0;
      hotspot_y_q     <= '0;
      cursor_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CURSOR_X:      cursor_x_q      <= cfg_data_i;
        REG_CURSOR_Y:      cursor_y_q      <= cfg_data_i;
        REG_HOTSPOT_X:     hotspot_x_q     <= cfg_data_i[7:0];
        REG_HOTSPOT_Y:     hotspot_y_q     <= cfg_data_i[7:0];
        REG_CURSOR_ENABLE: cursor_enable_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign corner_x = {cursor_x_q[15], cursor_x_q} + {{9{hotspot_x_q[7]}}, hotspot_x_q};
  assign corner_y = {cursor_y_q[15], cursor_y_q} + {{9{hotspot_y_q[7]}}, hotspot_y_q};

  assign pix.opcode           = pix_i.opcode;
  assign pix.pixel_x          = pix_i.pixel_x;
  assign pix.pixel_y          = pix_i.pixel_y;
  assign pix.background_pixel = pix_i.background_pixel;
  assign pix.table_index      = pix_i.table_index;
  assign pix.table_data       = pix_i.table_data;

  assign en3         = !s3_valid || res_o.ready;
  assign en2         = !s2_valid || en3;
  assign en1         = !s1_valid || en2;
  assign pix_i.ready = en1;
  assign acc         = pix_i.valid && en1;

  hco_sprite #(
    .CURSOR_SIZE(CURSOR_SIZE)
  ) u_sprite (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en1),
    .acc_i          (acc),
    .pix_i          (pix),
    .cursor_enable_i(cursor_enable_q),
    .corner_x_i     (corner_x),
    .corner_y_i     (corner_y),
    .s1_valid_o     (s1_valid),
    .s1_o           (s1),
    .spr_data_o     (spr_data)
  );

  hco_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en2),
    .s1_valid_i(s1_valid),
    .s1_i      (s1),
    .spr_data_i(spr_data),
    .s2_valid_o(s2_valid),
    .s2_o      (s2),
    .pal_data_o(pal_data)
  );

  hco_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en3),
    .s2_valid_i(s2_valid),
    .s2_i      (s2),
    .pal_data_i(pal_data),
    .valid_o   (s3_valid),
    .pixel_o   (res_o.pixel_out),
    .drawn_o   (res_o.cursor_drawn)
  );

  assign res_o.valid = s3_valid;

  // Input back-pressure only appears when every stage holds an entry and the sink stalls.
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (s1_valid && s2_valid && s3_valid && !res_o.ready))
    else $error("input stalled while the pipeline had room");

  // A palette write moving out of the first stage must not create a result.
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && en2 && !s1.is_pix) |=> !s2_valid)
    else $error("write transaction produced a pipeline entry");

  // A drawn cursor pixel always carries a nonzero alpha.
  a_drawn_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.cursor_drawn) |-> (res_o.pixel_out[15:12] != 4'd0))
    else $error("cursor drawn with zero alpha");

endmodule

[sim/hardware_cursor_overlay_tb.sv]
`timescale 1ns / 1ps

module hardware_cursor_overlay_tb;
  import hco_pkg::*;

  localparam int SpriteSide = 16;
  localparam int TableDepth = 256;
  localparam int PipeLatency = 3;
  localparam int MaxCoord = 4095;
  localparam int HoldLen = 150;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            drawn;
  } overlay_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;

  hco_pix_if pix_if ();
  hco_res_if res_if ();

  hardware_cursor_overlay u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  logic signed [15:0] cur_x = '0;
  logic signed [15:0] cur_y = '0;
  logic signed [7:0]  hot_x = '0;
  logic signed [7:0]  hot_y = '0;
  logic               cur_en = 1'b1;
  logic [7:0]         sprite_mem [TableDepth];
  logic [15:0]        palette_mem [TableDepth];
  bit                 sprite_written [TableDepth];
  bit                 palette_written [TableDepth];
  overlay_res_t       pending_pixels [$];
  int                 errors = 0;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 hold_cycles = 0;
  bit                 hold_start = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int cursor_slot(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    int h;
    int v;
    h = int'(x) - (int'(cur_x) + int'(hot_x));
    v = int'(y) - (int'(cur_y) + int'(hot_y));
    if (!cur_en || h < 0 || h >= SpriteSide || v < 0 || v >= SpriteSide) return -1;
    return v * SpriteSide + h;
  endfunction

  function automatic logic [3:0] blend_channel(logic [3:0] bg, logic [3:0] fg, logic [3:0] a);
    int acc;
    acc = int'(bg) * (16 - int'(a)) + int'(fg) * (int'(a) + 1);
    return 4'(acc >> 4);
  endfunction

  function automatic overlay_res_t composite_pixel(pix_t it);
    overlay_res_t res;
    int           slot;
    logic [15:0]  fg;
    logic [15:0]  bg;
    bg = it.background_pixel;
    res.pixel = bg;
    res.drawn = 1'b0;
    slot = cursor_slot(it.pixel_x, it.pixel_y);
    if (slot >= 0) begin
      fg = palette_mem[sprite_mem[slot]];
      if (fg[15:12] != 4'd0) begin
        res.pixel = {fg[15:12], blend_channel(bg[11:8], fg[11:8], fg[15:12]),
                     blend_channel(bg[7:4], fg[7:4], fg[15:12]),
                     blend_channel(bg[3:0], fg[3:0], fg[15:12])};
        res.drawn = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void apply_transaction(pix_t it);
    case (it.opcode)
      OP_PIXEL: pending_pixels = {pending_pixels, composite_pixel(it)};
      OP_SPRITE_WR: begin
        sprite_mem[it.table_index] = it.table_data[7:0];
        sprite_written[it.table_index] = 1'b1;
      end
      OP_PALETTE_WR: begin
        palette_mem[it.table_index] = it.table_data;
        palette_written[it.table_index] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input pix_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.opcode <= it.opcode;
    pix_if.pixel_x <= it.pixel_x;
    pix_if.pixel_y <= it.pixel_y;
    pix_if.background_pixel <= it.background_pixel;
    pix_if.table_index <= it.table_index;
    pix_if.table_data <= it.table_data;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    apply_transaction(it);
  endtask

  task automatic send_write(input opcode_e op, input logic [7:0] idx, input logic [15:0] data);
    pix_t it;
    it = '{op, 12'($urandom), 12'($urandom), 16'($urandom), idx, data};
    send_item(it);
  endtask

  // A covered pixel must only read sprite and palette entries that hold data.
  task automatic send_pixel(input logic [11:0] x, input logic [11:0] y, input logic [15:0] bg);
    pix_t it;
    int   slot;
    slot = cursor_slot(x, y);
    if (slot >= 0) begin
      if (!sprite_written[slot]) send_write(OP_SPRITE_WR, 8'(slot), 16'($urandom));
      if (!palette_written[sprite_mem[slot]])
        send_write(OP_PALETTE_WR, sprite_mem[slot], 16'($urandom));
    end
    it = '{OP_PIXEL, x, y, bg, 8'($urandom), 16'($urandom)};
    send_item(it);
  endtask

  task automatic send_random_item();
    int          pick;
    int          x;
    int          y;
    bit          far;
    logic [15:0] data;
    pix_t        it;
    pick = $urandom_range(99);
    if (pick < 14) begin
      send_write(OP_SPRITE_WR, 8'($urandom), 16'($urandom));
    end else if (pick < 26) begin
      data = 16'($urandom);
      if ($urandom_range(4) == 0) data[15:12] = 4'd0;
      send_write(OP_PALETTE_WR, 8'($urandom), data);
    end else if (pick < 29) begin
      it = '{OpUnused, 12'($urandom), 12'($urandom), 16'($urandom), 8'($urandom),
             16'($urandom)};
      send_item(it);
    end else begin
      far = $urandom_range(99) < 35;
      x = int'(cur_x) + int'(hot_x) + int'($urandom_range(19)) - 2;
      y = int'(cur_y) + int'(hot_y) + int'($urandom_range(19)) - 2;
      if (far || x < 0 || x > MaxCoord) x = $urandom_range(MaxCoord);
      if (far || y < 0 || y > MaxCoord) y = $urandom_range(MaxCoord);
      send_pixel(12'(x), 12'(y), 16'($urandom));
    end
  endtask

  task automatic drain();
    pix_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  task automatic set_cursor(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [7:0] hx, input logic [7:0] hy, input logic en);
    cfg_reg_e       regs [5];
    logic [CfgW-1:0] vals [5];
    drain();
    regs = '{REG_CURSOR_X, REG_CURSOR_Y, REG_HOTSPOT_X, REG_HOTSPOT_Y, REG_CURSOR_ENABLE};
    vals = '{cx, cy, {8'($urandom), hx}, {8'($urandom), hy}, {15'($urandom), en}};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_x = cx;
    cur_y = cy;
    hot_x = hx;
    hot_y = hy;
    cur_en = en;
  endtask

  always @(posedge clk_i) begin
    if (hold_start && hold_cycles < HoldLen) begin
      res_if.ready <= 1'b0;
      hold_cycles = hold_cycles + 1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    overlay_res_t exp_res;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got pixel_out %h cursor_drawn %b",
                 $time, res_if.pixel_out, res_if.cursor_drawn);
        errors++;
      end else begin
        exp_res = pending_pixels.pop_front();
        if (res_if.pixel_out !== exp_res.pixel) begin
          $display("%0t: pixel_out mismatch, expected %h, got %h",
                   $time, exp_res.pixel, res_if.pixel_out);
          errors++;
        end
        if (res_if.cursor_drawn !== exp_res.drawn) begin
          $display("%0t: cursor_drawn mismatch, expected %b, got %b",
                   $time, exp_res.drawn, res_if.cursor_drawn);
          errors++;
        end
      end
    end
  end

  task automatic test_blend_alphas();
    send_write(OP_PALETTE_WR, 8'd0, 16'h0ABC);
    send_write(OP_PALETTE_WR, 8'd1, 16'hF5A3);
    send_write(OP_PALETTE_WR, 8'd2, 16'h1FFF);
    send_write(OP_PALETTE_WR, 8'd255, 16'hFFFF);
    send_write(OP_PALETTE_WR, 8'd128, 16'h8000);
    send_write(OP_SPRITE_WR, 8'd0, 16'hFF01);
    send_write(OP_SPRITE_WR, 8'd15, 16'h0002);
    send_write(OP_SPRITE_WR, 8'd240, 16'h0080);
    send_write(OP_SPRITE_WR, 8'd255, 16'h00FF);
    send_write(OP_SPRITE_WR, 8'd17, 16'h0000);
    send_pixel(12'd0, 12'd0, 16'h0000);
    send_pixel(12'd15, 12'd0, 16'hFFFF);
    send_pixel(12'd0, 12'd15, 16'hFFFF);
    send_pixel(12'd15, 12'd15, 16'h0000);
    send_pixel(12'd1, 12'd1, 16'h1234);
    send_pixel(12'd16, 12'd0, 16'hFFFF);
    send_pixel(12'd0, 12'd16, 16'hFFFF);
    send_pixel(12'd4095, 12'd4095, 16'hFFFF);
  endtask

  task automatic test_ignored_items();
    pix_t it;
    it = '{OpUnused, 12'hFFF, 12'hFFF, 16'hFFFF, 8'd0, 16'h00FF};
    send_item(it);
    it = '{OpUnused, 12'd0, 12'd0, 16'h0000, 8'd1, 16'h0000};
    send_item(it);
    send_pixel(12'd0, 12'd0, 16'h7777);
  endtask

  task automatic test_cursor_disable();
    set_cursor(16'd0, 16'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(12'd0, 12'd0, 16'h1234);
    repeat (20) send_random_item();
    set_cursor(16'd0, 16'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(12'd0, 12'd0, 16'h1234);
  endtask

  task automatic test_window_edges();
    logic [15:0] cxs [5];
    logic [15:0] cys [5];
    logic [7:0]  hxs [5];
    logic [7:0]  hys [5];
    cxs = '{16'h8000, 16'h7FFF, 16'hFFF8, 16'd4000, 16'd4090};
    cys = '{16'h7FFF, 16'h8000, 16'd4090, 16'd3000, 16'd120};
    hxs = '{8'h7F, 8'h80, 8'h00, 8'h80, 8'h05};
    hys = '{8'h80, 8'h7F, 8'h00, 8'h7F, 8'h80};
    for (int i = 0; i < 5; i++) begin
      set_cursor(cxs[i], cys[i], hxs[i], hys[i], 1'b1);
      repeat (15) send_random_item();
    end
  endtask

  task automatic test_random_traffic();
    int idle_pcts [4];
    int stall_pcts [4];
    idle_pcts = '{0, 57, 0, 25};
    stall_pcts = '{0, 0, 57, 25};
    for (int i = 0; i < 4; i++) begin
      set_cursor(16'($urandom_range(4200) - 64), 16'($urandom_range(4200) - 64),
                 8'($urandom), 8'($urandom), 1'b1);
      send_idle_pct = idle_pcts[i];
      stall_pct = stall_pcts[i];
      repeat (110) send_random_item();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    set_cursor(16'd200, 16'd300, 8'hF8, 8'h04, 1'b1);
    hold_start = 1'b1;
    repeat (60) send_random_item();
  endtask

  initial begin
    pix_if.valid = 1'b0;
    pix_if.opcode = '0;
    pix_if.pixel_x = '0;
    pix_if.pixel_y = '0;
    pix_if.background_pixel = '0;
    pix_if.table_index = '0;
    pix_if.table_data = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_blend_alphas();
    test_ignored_items();
    test_cursor_disable();
    test_window_edges();
    test_random_traffic();
    test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
